FILE: hdl/pwi_pkg.sv
// Shared types and constants for the pulse window integrator.
// Holds field widths, register defaults, FSM state type and control structs.
// No dependencies.
package pwi_pkg;

	localparam int CHANNELS  = 9;
	localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CH_W      = 4;
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 12;
	localparam int GRP_W     = 2;
	localparam int THR_W     = 12;
	localparam int LEN_W     = 10;
	localparam int HIGH_W    = 11;
	localparam int CNT_W     = 2;
	localparam int ACC_W     = 35;
	localparam int BASE_W    = 22;
	localparam int PROD_W    = VAL_W + LEN_W;
	localparam int DIFF_W    = BASE_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	localparam logic [THR_W-1:0]  THR_RST     = THR_W'(3000);
	localparam logic [LEN_W-1:0]  BLEN_RST    = LEN_W'(100);
	localparam logic [IDX_W-1:0]  EARLY_RST   = IDX_W'(200);
	localparam logic [IDX_W-1:0]  LEAD_LO_RST = IDX_W'(160);
	localparam logic [IDX_W-1:0]  LEAD_HI_RST = IDX_W'(200);
	localparam logic [IDX_W-1:0]  SEC_LO_RST  = IDX_W'(200);
	localparam logic [HIGH_W-1:0] SEC_HI_RST  = HIGH_W'(1000);

	localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
	localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
	localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_BASE_LEN  = 3'd1,
		REG_EARLY     = 3'd2,
		REG_LEAD_LO   = 3'd3,
		REG_LEAD_HI   = 3'd4,
		REG_SEC_LO    = 3'd5,
		REG_SEC_HI    = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic walk_start;
		logic walk_step;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic walk_last;
		logic out_free;
	} status_t;

endpackage

FILE: hdl/pulse_window_integrator.sv
// Top level of the pulse window integrator.
// Joins pwi_ctrl and pwi_datapath; depends on pwi_pkg.
//
// Usage:
//   Sample channel: sample_valid/sample_stall carry kind, channel, sample_index,
//   sample_value and group. A transaction completes on a clock edge with
//   sample_valid high and sample_stall low.
//   A kept sample (group 0, index below second_high, channel in range) passes
//   through capture, product register (value times baseline_length), then
//   read-modify-write of the channel's accumulators. An ignored one is dropped.
//   An end-of-event transaction walks the channels one per cycle, while the
//   receiver does not stall, through the result register, giving one result
//   per channel, last set on the final one.
//   Per-channel state clears as the last result is loaded.
//   Result channel: result_valid/result_stall; a stalled result holds and the
//   walk waits. The next sample can be taken while the last result waits.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while the block is idle.
//   Reset (arst_n low) loads the register defaults and zeroes all channels.
module pulse_window_integrator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic                          kind,
	input  logic [pwi_pkg::CH_W-1:0]      channel,
	input  logic [pwi_pkg::IDX_W-1:0]     sample_index,
	input  logic [pwi_pkg::VAL_W-1:0]     sample_value,
	input  logic [pwi_pkg::GRP_W-1:0]     group,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pwi_pkg::CH_W-1:0]      result_channel,
	output logic [pwi_pkg::CNT_W-1:0]     pulse_count,
	output logic signed [pwi_pkg::ACC_W-1:0] lead_integral,
	output logic signed [pwi_pkg::ACC_W-1:0] second_integral,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwi_pkg::CFG_DAT_W-1:0] cfg_data
);
	import pwi_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	pwi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.kind         (kind),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	pwi_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.channel         (channel),
		.sample_index    (sample_index),
		.sample_value    (sample_value),
		.group           (group),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.result_channel  (result_channel),
		.pulse_count     (pulse_count),
		.lead_integral   (lead_integral),
		.second_integral (second_integral),
		.last            (last),
		.cmd             (cmd),
		.status          (status)
	);

endmodule

FILE: hdl/pwi_ctrl.sv
// Controller state machine for the pulse window integrator.
// Sequences sample capture, multiply, update and the end-of-event walk.
// Depends on pwi_pkg.
module pwi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              kind,
	output logic              sample_stall,
	input  pwi_pkg::status_t  status,
	output pwi_pkg::cmd_t     cmd
);
	import pwi_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					if (kind) begin
						cmd.walk_start = 1'b1;
						state_nxt      = ST_EMIT;
					end else begin
						state_nxt = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				// drop samples outside the record, channel range or group
				state_nxt = status.keep ? ST_UPD : ST_IDLE;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nxt  = ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					if (status.walk_last) begin
						cmd.clear = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						cmd.walk_step = 1'b1;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/pwi_datapath.sv
// Datapath for the pulse window integrator: config registers, per-channel
// accumulators, product register and result output register.
// Depends on pwi_pkg.
module pwi_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pwi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwi_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic [pwi_pkg::CH_W-1:0]      channel,
	input  logic [pwi_pkg::IDX_W-1:0]     sample_index,
	input  logic [pwi_pkg::VAL_W-1:0]     sample_value,
	input  logic [pwi_pkg::GRP_W-1:0]     group,
	input  logic                          result_stall,
	output logic                          result_valid,
	output logic [pwi_pkg::CH_W-1:0]      result_channel,
	output logic [pwi_pkg::CNT_W-1:0]     pulse_count,
	output logic signed [pwi_pkg::ACC_W-1:0] lead_integral,
	output logic signed [pwi_pkg::ACC_W-1:0] second_integral,
	output logic                          last,
	input  pwi_pkg::cmd_t                 cmd,
	output pwi_pkg::status_t              status
);
	import pwi_pkg::*;

	// configuration
	logic [THR_W-1:0]  thr_q;
	logic [LEN_W-1:0]  blen_q;
	logic [IDX_W-1:0]  early_q;
	logic [IDX_W-1:0]  lead_lo_q;
	logic [IDX_W-1:0]  lead_hi_q;
	logic [IDX_W-1:0]  sec_lo_q;
	logic [HIGH_W-1:0] sec_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RST;
			blen_q    <= BLEN_RST;
			early_q   <= EARLY_RST;
			lead_lo_q <= LEAD_LO_RST;
			lead_hi_q <= LEAD_HI_RST;
			sec_lo_q  <= SEC_LO_RST;
			sec_hi_q  <= SEC_HI_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				REG_BASE_LEN:  blen_q    <= cfg_data[LEN_W-1:0];
				REG_EARLY:     early_q   <= cfg_data[IDX_W-1:0];
				REG_LEAD_LO:   lead_lo_q <= cfg_data[IDX_W-1:0];
				REG_LEAD_HI:   lead_hi_q <= cfg_data[IDX_W-1:0];
				REG_SEC_LO:    sec_lo_q  <= cfg_data[IDX_W-1:0];
				REG_SEC_HI:    sec_hi_q  <= cfg_data[HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// captured sample
	logic [CH_W-1:0]   ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VAL_W-1:0]  val_q;
	logic [GRP_W-1:0]  grp_q;
	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= channel;
			idx_q <= sample_index;
			val_q <= sample_value;
			grp_q <= group;
		end
		prod_q <= val_q * blen_q;
	end

	assign status.keep = (grp_q == '0) && ({1'b0, idx_q} < sec_hi_q) &&
		({1'b0, ch_q} < (CH_W+1)'(CHANNELS));

	// per-channel state
	logic [BASE_W-1:0] base_q  [CHANNELS];
	logic [ACC_W-1:0]  lead_q  [CHANNELS];
	logic [ACC_W-1:0]  sec_q   [CHANNELS];
	logic              low_q   [CHANNELS];
	logic              early_seen_q [CHANNELS];
	logic [CH_IDX_W-1:0] walk_q;

	logic [CH_IDX_W-1:0] rd_idx;
	logic [BASE_W-1:0]   base_rd;
	logic [ACC_W-1:0]    lead_rd;
	logic [ACC_W-1:0]    sec_rd;
	logic                low_rd;
	logic                early_rd;

	assign rd_idx   = cmd.update ? ch_q[CH_IDX_W-1:0] : walk_q;
	assign base_rd  = base_q[rd_idx];
	assign lead_rd  = lead_q[rd_idx];
	assign sec_rd   = sec_q[rd_idx];
	assign low_rd   = low_q[rd_idx];
	assign early_rd = early_seen_q[rd_idx];

	logic              low_nxt;
	logic              early_nxt;
	logic              in_base;
	logic              in_lead;
	logic              in_sec;
	logic [BASE_W:0]   base_sum;
	logic [BASE_W-1:0] base_nxt;
	logic signed [DIFF_W-1:0] diff;
	logic [ACC_W-1:0]  acc_sel;
	logic signed [ACC_W:0] acc_sum;
	logic [ACC_W-1:0]  acc_nxt;

	always_comb begin
		low_nxt   = low_rd || (val_q < thr_q);
		early_nxt = early_rd || ((idx_q < early_q) && low_nxt);
		in_base   = idx_q < blen_q;
		in_lead   = !in_base && (idx_q > lead_lo_q) && (idx_q < lead_hi_q);
		in_sec    = !in_base && !in_lead && (idx_q > sec_lo_q) &&
			({1'b0, idx_q} < sec_hi_q);
		base_sum  = {1'b0, base_rd} + (BASE_W+1)'(val_q);
		base_nxt  = base_sum[BASE_W] ? BASE_MAX : base_sum[BASE_W-1:0];
		diff      = $signed({2'b00, base_rd}) - $signed({2'b00, prod_q});
		acc_sel   = in_lead ? lead_rd : sec_rd;
		acc_sum   = $signed({acc_sel[ACC_W-1], acc_sel}) + (ACC_W+1)'(diff);
		// saturate when the two top bits disagree
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_nxt = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_nxt = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i]       <= '0;
				lead_q[i]       <= '0;
				sec_q[i]        <= '0;
				low_q[i]        <= 1'b0;
				early_seen_q[i] <= 1'b0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i]       <= '0;
				lead_q[i]       <= '0;
				sec_q[i]        <= '0;
				low_q[i]        <= 1'b0;
				early_seen_q[i] <= 1'b0;
			end
		end else if (cmd.update) begin
			low_q[rd_idx]        <= low_nxt;
			early_seen_q[rd_idx] <= early_nxt;
			if (in_base) begin
				base_q[rd_idx] <= base_nxt;
			end
			if (in_lead) begin
				lead_q[rd_idx] <= acc_nxt;
			end
			if (in_sec) begin
				sec_q[rd_idx] <= acc_nxt;
			end
		end
	end

	// channel walk for end of event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (cmd.walk_start) begin
			walk_q <= '0;
		end else if (cmd.walk_step) begin
			walk_q <= walk_q + 1'b1;
		end
	end

	assign status.walk_last = (walk_q == CH_IDX_W'(CHANNELS - 1));

	// result output register
	logic res_valid_q;

	assign status.out_free = !res_valid_q || !result_stall;
	assign result_valid    = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_channel  <= CH_W'(walk_q);
			lead_integral   <= lead_rd;
			second_integral <= sec_rd;
			last            <= status.walk_last;
			if (low_rd && early_rd) begin
				pulse_count <= CNT_TWO;
			end else if (low_rd || early_rd) begin
				pulse_count <= CNT_ONE;
			end else begin
				pulse_count <= CNT_NONE;
			end
		end
	end

endmodule
